FILE: hw/rtl/pfx_pkg.sv
package pfx_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_STAR  = 8'h2a;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_CARET = 8'h5e;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [31:0] VALUE_EMPTY = 32'hffff_ffff;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    typedef logic [3:0] uop_t;
    localparam uop_t U_NOP     = 4'd0;
    localparam uop_t U_FETCH   = 4'd1;
    localparam uop_t U_POP     = 4'd2;
    localparam uop_t U_LDB     = 4'd3;
    localparam uop_t U_LDA     = 4'd4;
    localparam uop_t U_ADD     = 4'd5;
    localparam uop_t U_SUB     = 4'd6;
    localparam uop_t U_MUL     = 4'd7;
    localparam uop_t U_DIVINIT = 4'd8;
    localparam uop_t U_DIVSTEP = 4'd9;
    localparam uop_t U_DIVFIX  = 4'd10;
    localparam uop_t U_PWRINIT = 4'd11;
    localparam uop_t U_PWRSTEP = 4'd12;
    localparam uop_t U_PUSHR   = 4'd13;
    localparam uop_t U_PUSHSYM = 4'd14;
    localparam uop_t U_EMIT    = 4'd15;

    typedef logic [3:0] cond_t;
    localparam cond_t C_NEVER    = 4'd0;
    localparam cond_t C_ALWAYS   = 4'd1;
    localparam cond_t C_NO_ACC   = 4'd2;
    localparam cond_t C_NOT_OPER = 4'd3;
    localparam cond_t C_IS_SUB   = 4'd4;
    localparam cond_t C_IS_MUL   = 4'd5;
    localparam cond_t C_IS_DIV   = 4'd6;
    localparam cond_t C_IS_POW   = 4'd7;
    localparam cond_t C_CNT_MORE = 4'd8;
    localparam cond_t C_B_NEG    = 4'd9;
    localparam cond_t C_E_MORE   = 4'd10;
    localparam cond_t C_NOT_LAST = 4'd11;
    localparam cond_t C_OUT_BUSY = 4'd12;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic accept;
        logic is_oper;
        logic is_sub;
        logic is_mul;
        logic is_div;
        logic is_pow;
        logic cnt_more;
        logic b_neg;
        logic e_more;
        logic last;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               overflow_seen;
        logic               underflow_seen;
        logic               div_zero_seen;
    } out_word_t;

endpackage

FILE: hw/rtl/pfx_useq.sv
module pfx_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfx_pkg::status_t  status,
    output pfx_pkg::uop_t     op
);
    import pfx_pkg::*;

    localparam upc_t L_FETCH   = 5'd0;
    localparam upc_t L_SUB     = 5'd10;
    localparam upc_t L_MUL     = 5'd11;
    localparam upc_t L_DIV     = 5'd12;
    localparam upc_t L_DIVLOOP = 5'd13;
    localparam upc_t L_POW     = 5'd15;
    localparam upc_t L_PWRLOOP = 5'd16;
    localparam upc_t L_PUSHR   = 5'd17;
    localparam upc_t L_PUSHSYM = 5'd19;
    localparam upc_t L_FINAL   = 5'd20;
    localparam upc_t L_EMIT    = 5'd21;

    upc_t       upc_reg;
    upc_t       upc_next;
    ctrl_word_t cw;
    logic       cond_true;

    always_comb begin
        unique case (upc_reg)
            5'd0:  cw = '{op: U_FETCH,   cond: C_NO_ACC,   target: L_FETCH};
            5'd1:  cw = '{op: U_NOP,     cond: C_NOT_OPER, target: L_PUSHSYM};
            5'd2:  cw = '{op: U_POP,     cond: C_NEVER,    target: L_FETCH};
            5'd3:  cw = '{op: U_LDB,     cond: C_NEVER,    target: L_FETCH};
            5'd4:  cw = '{op: U_POP,     cond: C_NEVER,    target: L_FETCH};
            5'd5:  cw = '{op: U_LDA,     cond: C_IS_SUB,   target: L_SUB};
            5'd6:  cw = '{op: U_NOP,     cond: C_IS_MUL,   target: L_MUL};
            5'd7:  cw = '{op: U_NOP,     cond: C_IS_DIV,   target: L_DIV};
            5'd8:  cw = '{op: U_NOP,     cond: C_IS_POW,   target: L_POW};
            5'd9:  cw = '{op: U_ADD,     cond: C_ALWAYS,   target: L_PUSHR};
            5'd10: cw = '{op: U_SUB,     cond: C_ALWAYS,   target: L_PUSHR};
            5'd11: cw = '{op: U_MUL,     cond: C_ALWAYS,   target: L_PUSHR};
            5'd12: cw = '{op: U_DIVINIT, cond: C_NEVER,    target: L_FETCH};
            5'd13: cw = '{op: U_DIVSTEP, cond: C_CNT_MORE, target: L_DIVLOOP};
            5'd14: cw = '{op: U_DIVFIX,  cond: C_ALWAYS,   target: L_PUSHR};
            5'd15: cw = '{op: U_PWRINIT, cond: C_B_NEG,    target: L_PUSHR};
            5'd16: cw = '{op: U_PWRSTEP, cond: C_E_MORE,   target: L_PWRLOOP};
            5'd17: cw = '{op: U_PUSHR,   cond: C_NOT_LAST, target: L_FETCH};
            5'd18: cw = '{op: U_NOP,     cond: C_ALWAYS,   target: L_FINAL};
            5'd19: cw = '{op: U_PUSHSYM, cond: C_NOT_LAST, target: L_FETCH};
            5'd20: cw = '{op: U_POP,     cond: C_NEVER,    target: L_FETCH};
            5'd21: cw = '{op: U_EMIT,    cond: C_OUT_BUSY, target: L_EMIT};
            default: cw = '{op: U_NOP,   cond: C_ALWAYS,   target: L_FETCH};
        endcase
    end

    always_comb begin
        unique case (cw.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_ACC:   cond_true = !status.accept;
            C_NOT_OPER: cond_true = !status.is_oper;
            C_IS_SUB:   cond_true = status.is_sub;
            C_IS_MUL:   cond_true = status.is_mul;
            C_IS_DIV:   cond_true = status.is_div;
            C_IS_POW:   cond_true = status.is_pow;
            C_CNT_MORE: cond_true = status.cnt_more;
            C_B_NEG:    cond_true = status.b_neg;
            C_E_MORE:   cond_true = status.e_more;
            C_NOT_LAST: cond_true = !status.last;
            C_OUT_BUSY: cond_true = status.out_busy;
            default:    cond_true = 1'b0;
        endcase
    end

    assign upc_next = cond_true ? cw.target : upc_t'(upc_reg + 1'b1);
    assign op       = cw.op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= L_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: hw/rtl/postfix_expression_evaluator.sv
// Operators run longer than plain characters; ^ and $ with a negative exponent skip the squaring
// loop, else its length is set by the exponent's highest set bit. A last word also waits on m_ready.
// A new word is accepted only after the previous word's micro-program has finished; the 32-step
// divider loop is the longest.
// Reset: synchronous, active low; clears sequencer, stack pointer, flags and m_valid.
// Stack memory contents are not cleared.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pfx_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output pfx_pkg::out_word_t m_word
);
    import pfx_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    logic [31:0] stack_mem [STACK_DEPTH];

    uop_t      op;
    status_t   status;

    logic [7:0]     sym_reg, sym_next;
    logic           last_reg, last_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic           empty_reg, empty_next;
    logic           ovf_reg, ovf_next;
    logic           unf_reg, unf_next;
    logic           dvz_reg, dvz_next;
    logic [31:0]    a_reg, a_next;
    logic [31:0]    b_reg, b_next;
    logic [31:0]    r_reg, r_next;
    logic [31:0]    rem_reg, rem_next;
    logic           neg_reg, neg_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [31:0]    rd_data_reg;
    logic           m_valid_reg, m_valid_next;
    out_word_t      m_word_reg, m_word_next;

    logic           mem_we;
    logic           mem_re;
    logic [31:0]    mem_wdata;
    logic [SPW-1:0] sp_dec;
    logic [AW-1:0]  pop_addr;
    logic [31:0]    mul_src;
    logic [31:0]    prod_a;
    logic [31:0]    prod_sq;
    logic [32:0]    trial;
    logic [32:0]    trial_diff;
    logic [31:0]    sym_val;
    logic [31:0]    pop_val;
    logic           out_free;

    pfx_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    assign s_ready = (op == U_FETCH);
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    assign sp_dec     = sp_reg - SPW'(1);
    assign pop_addr   = sp_dec[AW-1:0];
    assign mul_src    = (op == U_MUL) ? b_reg : r_reg;
    assign prod_a     = a_reg * mul_src;
    assign prod_sq    = a_reg * a_reg;
    assign trial      = {rem_reg, a_reg[31]};
    assign trial_diff = trial - {1'b0, b_reg};
    assign sym_val    = {24'd0, sym_reg} - {24'd0, CHAR_ZERO};
    assign pop_val    = empty_reg ? VALUE_EMPTY : rd_data_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        status.accept   = s_valid && s_ready;
        status.is_sub   = (sym_reg == CHAR_MINUS);
        status.is_mul   = (sym_reg == CHAR_STAR);
        status.is_div   = (sym_reg == CHAR_SLASH);
        status.is_pow   = (sym_reg == CHAR_CARET) || (sym_reg == CHAR_DOLLAR);
        status.is_oper  = (sym_reg == CHAR_PLUS) || status.is_sub || status.is_mul ||
                          status.is_div || status.is_pow;
        status.cnt_more = (cnt_reg != 5'd31);
        status.b_neg    = b_reg[31];
        status.e_more   = (b_reg[31:1] != 31'd0);
        status.last     = last_reg;
        status.out_busy = !out_free;
    end

    always_comb begin
        sym_next     = sym_reg;
        last_next    = last_reg;
        sp_next      = sp_reg;
        empty_next   = empty_reg;
        ovf_next     = ovf_reg;
        unf_next     = unf_reg;
        dvz_next     = dvz_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        r_next       = r_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = r_reg;

        unique case (op) inside
            U_FETCH: begin
                if (s_valid) begin
                    sym_next  = s_word.symbol;
                    last_next = s_word.last;
                end
            end
            U_POP: begin
                empty_next = (sp_reg == '0);
                if (sp_reg == '0) begin
                    unf_next = 1'b1;
                end else begin
                    sp_next = sp_dec;
                    mem_re  = 1'b1;
                end
            end
            U_LDB: b_next = pop_val;
            U_LDA: a_next = pop_val;
            U_ADD: r_next = a_reg + b_reg;
            U_SUB: r_next = a_reg - b_reg;
            U_MUL: r_next = prod_a;
            U_DIVINIT: begin
                a_next   = a_reg[31] ? (32'd0 - a_reg) : a_reg;
                b_next   = b_reg[31] ? (32'd0 - b_reg) : b_reg;
                rem_next = '0;
                neg_next = a_reg[31] ^ b_reg[31];
                cnt_next = '0;
                if (b_reg == '0) begin
                    dvz_next = 1'b1;
                end
            end
            U_DIVSTEP: begin
                if (!trial_diff[32]) begin
                    rem_next = trial_diff[31:0];
                    a_next   = {a_reg[30:0], 1'b1};
                end else begin
                    rem_next = trial[31:0];
                    a_next   = {a_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
            end
            U_DIVFIX: begin
                if (b_reg == '0) begin
                    r_next = '0;
                end else begin
                    r_next = neg_reg ? (32'd0 - a_reg) : a_reg;
                end
            end
            U_PWRINIT: begin
                if (b_reg[31]) begin
                    if (a_reg == 32'd1) begin
                        r_next = 32'd1;
                    end else if (a_reg == VALUE_EMPTY) begin
                        r_next = b_reg[0] ? VALUE_EMPTY : 32'd1;
                    end else begin
                        r_next = '0;
                        if (a_reg == '0) begin
                            dvz_next = 1'b1;
                        end
                    end
                end else begin
                    r_next = 32'd1;
                end
            end
            U_PWRSTEP: begin
                if (b_reg[0]) begin
                    r_next = prod_a;
                end
                a_next = prod_sq;
                b_next = {1'b0, b_reg[31:1]};
            end
            U_PUSHR, U_PUSHSYM: begin
                mem_wdata = (op == U_PUSHSYM) ? sym_val : r_reg;
                if (sp_reg == SP_FULL) begin
                    ovf_next = 1'b1;
                end else begin
                    mem_we  = 1'b1;
                    sp_next = sp_reg + SPW'(1);
                end
            end
            U_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = '{value: pop_val, overflow_seen: ovf_reg,
                                     underflow_seen: unf_reg, div_zero_seen: dvz_reg};
                    sp_next      = '0;
                    ovf_next     = 1'b0;
                    unf_next     = 1'b0;
                    dvz_next     = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[sp_reg[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= stack_mem[pop_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            empty_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            unf_reg     <= 1'b0;
            dvz_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sp_reg      <= sp_next;
            empty_reg   <= empty_next;
            ovf_reg     <= ovf_next;
            unf_reg     <= unf_next;
            dvz_reg     <= dvz_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        m_word_reg <= m_word_next;
    end

`ifndef NO_ASSERTIONS
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond depth");

    a_rise_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(op == U_EMIT))
        else $error("result word raised outside emit step");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == U_EMIT && out_free) |=>
            (sp_reg == '0 && !ovf_reg && !unf_reg && !dvz_reg))
        else $error("stack or flags not cleared after emit");

    a_div_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == U_DIVFIX) |-> ($past(op == U_DIVSTEP) && cnt_reg == 5'd0))
        else $error("divider loop ended early");
`endif

endmodule

FILE: tb/sv/postfix_expression_evaluator_tb.sv
module postfix_expression_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfx_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int CHAR_COUNT  = 1650;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    in_word_t  char_queue[$];
    out_word_t predicted_answers[$];
    out_word_t want;

    logic [31:0] eval_stack [DEPTH];
    int          eval_depth = 0;
    bit          seen_over = 0;
    bit          seen_under = 0;
    bit          seen_divz = 0;

    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_over = 0;
    int n_under = 0;
    int n_divz = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int idle_pct;

    assign idle_pct = (n_sent >= 700 && n_sent < 1000) ? 0 : 35;

    function automatic bit is_operator(input logic [7:0] sym);
        case (sym)
            CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_CARET, CHAR_DOLLAR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void eval_push(input logic [31:0] v);
        if (eval_depth >= DEPTH) begin
            seen_over = 1'b1;
        end else begin
            eval_stack[eval_depth] = v;
            eval_depth++;
        end
    endfunction

    function automatic logic [31:0] eval_pop();
        if (eval_depth == 0) begin
            seen_under = 1'b1;
            return VALUE_EMPTY;
        end
        eval_depth--;
        return eval_stack[eval_depth];
    endfunction

    function automatic logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        if (b == 32'd0) begin
            seen_divz = 1'b1;
            return 32'd0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] power(input logic [31:0] base, input logic [31:0] e);
        logic [31:0] r;
        r = 32'd1;
        if (e[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == '1) return e[0] ? '1 : 32'd1;
            if (base == 32'd0) seen_divz = 1'b1;
            return 32'd0;
        end
        while (e != 32'd0) begin
            if (e[0]) r = r * base;
            base = base * base;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic void evaluate_char(input in_word_t w);
        logic [31:0] a, b, r;
        out_word_t   o;
        if (is_operator(w.symbol)) begin
            b = eval_pop();
            a = eval_pop();
            case (w.symbol)
                CHAR_PLUS:  r = a + b;
                CHAR_MINUS: r = a - b;
                CHAR_STAR:  r = a * b;
                CHAR_SLASH: r = quotient(a, b);
                default:    r = power(a, b);
            endcase
            eval_push(r);
        end else begin
            eval_push({24'd0, w.symbol} - {24'd0, CHAR_ZERO});
        end
        if (w.last) begin
            o.value          = eval_pop();
            o.overflow_seen  = seen_over;
            o.underflow_seen = seen_under;
            o.div_zero_seen  = seen_divz;
            predicted_answers.push_back(o);
            eval_depth = 0;
            seen_over  = 1'b0;
            seen_under = 1'b0;
            seen_divz  = 1'b0;
        end
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 5))
            0: return CHAR_PLUS;
            1: return CHAR_MINUS;
            2: return CHAR_STAR;
            3: return CHAR_SLASH;
            4: return CHAR_CARET;
            default: return CHAR_DOLLAR;
        endcase
    endfunction

    function automatic logic [7:0] random_operand();
        logic [7:0] s;
        if ($urandom_range(0, 4) != 0) return CHAR_ZERO + 8'($urandom_range(0, 9));
        do s = 8'($urandom_range(0, 255)); while (is_operator(s));
        return s;
    endfunction

    task automatic queue_symbol(input logic [7:0] sym, input bit is_last);
        in_word_t w;
        w.symbol = sym;
        w.last   = is_last;
        char_queue.push_back(w);
    endtask

    task automatic queue_text(input string t);
        for (int i = 0; i < t.len(); i++) queue_symbol(t[i], i == t.len() - 1);
    endtask

    task automatic queue_expression(input int operands);
        int         depth, left;
        logic [7:0] sym;
        depth = 0;
        left  = operands;
        while (left > 0 || depth > 1) begin
            if (depth >= 2 && (left == 0 || $urandom_range(0, 2) == 0)) begin
                sym = random_operator();
                depth--;
            end else begin
                sym = random_operand();
                left--;
                depth++;
            end
            queue_symbol(sym, left == 0 && depth == 1);
        end
    endtask

    // push 60 to 70 operands, up to or past the stack limit, then fold one to three operators and close
    task automatic queue_deep();
        int n, k;
        n = $urandom_range(60, 70);
        k = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) queue_symbol(random_operand(), 1'b0);
        for (int j = 0; j < k; j++) queue_symbol(random_operator(), j == k - 1);
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            queue_symbol(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 7) == 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                evaluate_char(s_word);
                n_sent <= n_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_word  <= char_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results <= n_results + 1;
                n_over  += m_word.overflow_seen;
                n_under += m_word.underflow_seen;
                n_divz  += m_word.div_zero_seen;
                if (predicted_answers.size() == 0) begin
                    $display("%0t: unexpected word: value %0d flags %b%b%b", $time,
                             m_word.value, m_word.overflow_seen, m_word.underflow_seen,
                             m_word.div_zero_seen);
                    n_errors++;
                end else begin
                    want = predicted_answers.pop_front();
                    if (m_word !== want) begin
                        $display("%0t: expected value %0d flags %b%b%b, got value %0d flags %b%b%b",
                                 $time, want.value, want.overflow_seen, want.underflow_seen,
                                 want.div_zero_seen, m_word.value, m_word.overflow_seen,
                                 m_word.underflow_seen, m_word.div_zero_seen);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (n_results == 40 && !hold_done) begin
                hold_left <= 300;
                hold_done <= 1'b1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= $urandom_range(0, 99) >= idle_pct;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int roll;

        queue_symbol(8'h00, 1'b1);
        queue_symbol(8'hff, 1'b1);
        queue_text("34+2*");
        queue_text("30/");
        queue_text("2O^01-/");
        queue_text("01-#$");
        queue_text("1#^0 ^+");
        queue_text("+");

        while (char_queue.size() < CHAR_COUNT) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                queue_deep();
            else if (roll < 15)
                queue_noise();
            else
                queue_expression($urandom_range(0, 9) == 0 ? $urandom_range(9, 24)
                                                           : $urandom_range(1, 8));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_queue.size() != 0 || s_valid) @(negedge aclk);
        while (predicted_answers.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);

        $display("%0d characters sent, %0d expression results checked", n_sent, n_results);
        $display("results flagged: overflow %0d, underflow %0d, divide by zero %0d",
                 n_over, n_under, n_divz);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: postfix_expression_evaluator.f
hw/rtl/pfx_pkg.sv
hw/rtl/pfx_useq.sv
hw/rtl/postfix_expression_evaluator.sv
tb/sv/postfix_expression_evaluator_tb.sv
